### src/tfe_pkg.sv
// Package for the three-floor elevator controller: the controller state type,
// the state codes, the event codes, the reset door timeout and the floor codes. No dependencies.
package tfe_pkg;

    typedef enum logic [2:0] {
        ST_OPENING = 3'd0,
        ST_OPEN    = 3'd1,
        ST_CLOSING = 3'd2,
        ST_UP      = 3'd3,
        ST_DOWN    = 3'd4
    } ctrl_state_t;

    // Event codes carried on s_tuser
    localparam logic [3:0] EV_DOOR_BTN   = 4'd0;
    localparam logic [3:0] EV_UP_CALL    = 4'd1;
    localparam logic [3:0] EV_DOWN_CALL  = 4'd2;
    localparam logic [3:0] EV_CABIN_CALL = 4'd3;
    localparam logic [3:0] EV_OPENED     = 4'd4;
    localparam logic [3:0] EV_CLOSED     = 4'd5;
    localparam logic [3:0] EV_PASSING    = 4'd6;
    localparam logic [3:0] EV_STOPPED    = 4'd7;
    localparam logic [3:0] EV_TICK       = 4'd8;

    localparam logic [15:0] DOOR_TIMEOUT_RESET = 16'd500;
    localparam logic [1:0]  FLOOR_1 = 2'd1;
    localparam logic [1:0]  FLOOR_2 = 2'd2;
    localparam logic [1:0]  FLOOR_3 = 2'd3;

    typedef struct packed {
        ctrl_state_t mode_state;
        logic [1:0]  car_pos;
        logic        going_up;
        logic        going_down;
        logic [2:0]  up_calls;
        logic [2:0]  down_calls;
        logic [2:0]  cabin_calls;
        logic [15:0] timeout_count;
        logic        timer_armed;
        logic        door_cmd;
        logic [1:0]  target;
    } tfe_state_t;

endpackage

### src/tfe_core.sv
// Next-state logic of the elevator controller: one event applied to the
// current state. Purely combinational; depends on tfe_pkg.
module tfe_core
    import tfe_pkg::*;
(
    input  tfe_state_t  cur_state,
    input  logic [3:0]  ev_mode,
    input  logic [1:0]  ev_floor,
    input  logic [15:0] close_ticks,
    output tfe_state_t  next_state
);

    function automatic logic [2:0] bit_of(input logic [1:0] f);
        unique case (f)
            FLOOR_1: bit_of = 3'b001;
            FLOOR_2: bit_of = 3'b010;
            FLOOR_3: bit_of = 3'b100;
            default: bit_of = 3'b000;
        endcase
    endfunction

    function automatic logic has(input logic [2:0] m, input logic [1:0] f);
        has = |(m & bit_of(f));
    endfunction

    function automatic logic any_at(input tfe_state_t s, input logic [1:0] f);
        any_at = has(s.up_calls | s.down_calls | s.cabin_calls, f);
    endfunction

    function automatic logic hall_pending(input tfe_state_t s);
        hall_pending = |(s.up_calls | s.down_calls);
    endfunction

    function automatic logic [1:0] dest_up(input tfe_state_t s);
        if (any_at(s, FLOOR_2) && s.car_pos <= FLOOR_2) dest_up = FLOOR_2;
        else if (any_at(s, FLOOR_3))                    dest_up = FLOOR_3;
        else                                            dest_up = s.car_pos;
    endfunction

    function automatic logic [1:0] dest_down(input tfe_state_t s);
        if (any_at(s, FLOOR_2) && s.car_pos >= FLOOR_2) dest_down = FLOOR_2;
        else if (any_at(s, FLOOR_1))                    dest_down = FLOOR_1;
        else                                            dest_down = s.car_pos;
    endfunction

    function automatic logic should_rise(input tfe_state_t s);
        if (s.going_down || dest_up(s) == s.car_pos) should_rise = 1'b0;
        else if (s.car_pos == FLOOR_1)
            should_rise = has(s.cabin_calls, FLOOR_2) | has(s.cabin_calls, FLOOR_3) |
                          has(s.up_calls, FLOOR_2) | has(s.up_calls, FLOOR_3);
        else if (s.car_pos == FLOOR_2)
            should_rise = has(s.cabin_calls, FLOOR_3) | has(s.up_calls, FLOOR_3);
        else should_rise = 1'b0;
    endfunction

    function automatic logic should_sink(input tfe_state_t s);
        if (s.going_up || dest_down(s) == s.car_pos) should_sink = 1'b0;
        else if (s.car_pos == FLOOR_2)
            should_sink = has(s.cabin_calls, FLOOR_1) | has(s.down_calls, FLOOR_1);
        else if (s.car_pos == FLOOR_3)
            should_sink = has(s.cabin_calls, FLOOR_1) | has(s.cabin_calls, FLOOR_2) |
                          has(s.down_calls, FLOOR_1) | has(s.down_calls, FLOOR_2);
        else should_sink = 1'b0;
    endfunction

    function automatic logic rise_for_down(input tfe_state_t s);
        rise_for_down = (has(s.down_calls, FLOOR_2) && s.car_pos <= FLOOR_2) ||
                        has(s.down_calls, FLOOR_3);
    endfunction

    function automatic logic sink_for_up(input tfe_state_t s);
        sink_for_up = (has(s.up_calls, FLOOR_2) && s.car_pos > FLOOR_2) ||
                      (has(s.up_calls, FLOOR_1) && s.car_pos > FLOOR_1);
    endfunction

    function automatic tfe_state_t enter_opening(input tfe_state_t s);
        tfe_state_t r;
        logic [2:0] b;
        r = s;
        b = bit_of(s.car_pos);
        r.mode_state  = ST_OPENING;
        r.door_cmd    = 1'b0;
        r.cabin_calls = r.cabin_calls & ~b;
        if (s.car_pos == FLOOR_2) begin
            if (s.going_up) r.up_calls   = r.up_calls & ~b;
            else            r.down_calls = r.down_calls & ~b;
        end else begin
            // end floors: service direction turns around here
            r.up_calls   = r.up_calls & ~b;
            r.down_calls = r.down_calls & ~b;
            r.going_up   = (s.car_pos == FLOOR_1);
            r.going_down = (s.car_pos != FLOOR_1);
        end
        return r;
    endfunction

    function automatic tfe_state_t enter_open(input tfe_state_t s, input logic [15:0] tmo);
        tfe_state_t r;
        r = s;
        r.mode_state = ST_OPEN;
        if (r.going_up && !should_rise(r))   r.going_up = 1'b0;
        if (r.going_down && !should_sink(r)) r.going_down = 1'b0;
        if (r.cabin_calls != 3'b000 || hall_pending(r)) begin
            r.timeout_count = tmo;
            r.timer_armed   = 1'b1;
        end
        if (r.cabin_calls == 3'b000 && hall_pending(r)) begin
            if (rise_for_down(r)) begin
                r.going_up   = 1'b1;
                r.going_down = 1'b0;
            end else if (sink_for_up(r)) begin
                r.going_down = 1'b1;
                r.going_up   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic tfe_state_t enter_closing(input tfe_state_t s);
        tfe_state_t r;
        r = s;
        r.mode_state = ST_CLOSING;
        r.door_cmd   = 1'b1;
        return r;
    endfunction

    function automatic tfe_state_t enter_up(input tfe_state_t s);
        tfe_state_t r;
        r = s;
        r.mode_state = ST_UP;
        r.going_up   = 1'b1;
        r.going_down = 1'b0;
        r.target     = dest_up(s);
        return r;
    endfunction

    function automatic tfe_state_t enter_down(input tfe_state_t s);
        tfe_state_t r;
        r = s;
        r.mode_state = ST_DOWN;
        r.going_down = 1'b1;
        r.going_up   = 1'b0;
        r.target     = dest_down(s);
        return r;
    endfunction

    function automatic tfe_state_t latch_call(input tfe_state_t s, input logic [3:0] kind,
                                              input logic [1:0] f);
        tfe_state_t r;
        r = s;
        if (kind == EV_UP_CALL)        r.up_calls    = r.up_calls | bit_of(f);
        else if (kind == EV_DOWN_CALL) r.down_calls  = r.down_calls | bit_of(f);
        else                           r.cabin_calls = r.cabin_calls | bit_of(f);
        return r;
    endfunction

    function automatic tfe_state_t on_closed(input tfe_state_t s);
        tfe_state_t r;
        if (should_rise(s))      r = enter_up(s);
        else if (should_sink(s)) r = enter_down(s);
        else if (s.cabin_calls == 3'b000 && hall_pending(s) && rise_for_down(s))
            r = enter_up(s);
        else if (s.cabin_calls == 3'b000 && hall_pending(s) && sink_for_up(s))
            r = enter_down(s);
        else r = enter_opening(s);
        return r;
    endfunction

    function automatic tfe_state_t on_call(input tfe_state_t s, input logic [3:0] kind,
                                           input logic [1:0] f);
        tfe_state_t r;
        r = s;
        unique case (s.mode_state)
            ST_OPENING: if (f != s.car_pos) r = latch_call(s, kind, f);
            ST_OPEN:    if (f != s.car_pos) r = enter_closing(latch_call(s, kind, f));
            ST_CLOSING: begin
                if (f == s.car_pos) r = enter_opening(s);
                else                r = latch_call(s, kind, f);
            end
            ST_UP: begin
                r = latch_call(s, kind, f);
                if (kind != EV_DOWN_CALL) r.target = dest_up(r);
            end
            default: begin
                r = latch_call(s, kind, f);
                if (kind != EV_UP_CALL) r.target = dest_down(r);
            end
        endcase
        return r;
    endfunction

    function automatic tfe_state_t on_tick(input tfe_state_t s);
        tfe_state_t r;
        r = s;
        if (s.timer_armed) begin
            if (s.timeout_count <= 16'd1) begin
                r.timeout_count = 16'd0;
                r.timer_armed   = 1'b0;
                if (s.mode_state == ST_OPEN) r = enter_closing(r);
            end else begin
                r.timeout_count = s.timeout_count - 16'd1;
            end
        end
        return r;
    endfunction

    logic moving;

    always_comb begin
        moving     = (cur_state.mode_state == ST_UP) || (cur_state.mode_state == ST_DOWN);
        next_state = cur_state;
        if (ev_mode == EV_TICK) begin
            next_state = on_tick(cur_state);
        end else if (ev_mode == EV_DOOR_BTN) begin
            if (cur_state.mode_state == ST_CLOSING) next_state = enter_opening(cur_state);
        end else if (ev_mode < EV_TICK && ev_floor != 2'd0) begin
            if (ev_mode <= EV_CABIN_CALL) begin
                next_state = on_call(cur_state, ev_mode, ev_floor);
            end else if (ev_mode == EV_OPENED) begin
                if (cur_state.mode_state == ST_OPENING)
                    next_state = enter_open(cur_state, close_ticks);
            end else if (ev_mode == EV_CLOSED) begin
                if (cur_state.mode_state == ST_CLOSING) next_state = on_closed(cur_state);
            end else if (ev_mode == EV_PASSING) begin
                if (moving) next_state.car_pos = ev_floor;
            end else if (moving) begin
                next_state.car_pos = ev_floor;
                next_state = enter_opening(next_state);
            end
        end
    end

endmodule

### src/three_floor_elevator_controller_unit.sv
// Top level of the three-floor elevator controller: input register, state
// registers and result register around tfe_core. Depends on tfe_pkg, tfe_core.
//
// Usage:
//   Events enter on the s_ stream: s_tuser carries the event code (door
//   button, hall up/down call, cabin call, door opened/closed, passing floor,
//   stopped at floor, tick) and s_tdata the floor it refers to. Every event
//   yields exactly one snapshot on the m_ stream: controller state, car floor,
//   direction flags, the nine call lamps, door command, car target and
//   whether the door timeout counter is armed, all as they stand after the
//   event.
//   The door timeout (in ticks) is set through cfg_we/cfg_wdata; write it
//   only while no event is in flight.
//   An accepted item is first held in the input register; its snapshot shows
//   on m_tdata once the next-state logic loads the result register.
//   Throughput is one item per cycle while the receiver does not stall; the
//   next-state logic feeds the state registers directly, so back-to-back
//   events are fine.
//   When the receiver stalls, the result register holds its item, the input
//   register takes one more item, and s_tready then drops until m_tready
//   returns.
//   Reset (aresetn low, synchronous): door opening at floor 1, direction up,
//   no calls, timer disarmed, door commanded open, target floor 1, timeout
//   500 ticks, both stream stages empty.
module three_floor_elevator_controller_unit
    import tfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: door timeout in ticks
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // event stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] floor, [7:2] zero
    input  logic [3:0]  s_tuser,   // [3:0] mode (event code)
    // snapshot stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [2:0] ctrl_state, [4:3] car_floor, [5] dir_up,
                                   // [6] dir_down, [9:7] up_lamps, [12:10] down_lamps,
                                   // [15:13] cabin_lamps, [16] door_close_cmd,
                                   // [18:17] car_target, [19] timer_running, [23:20] zero
);

    // config register
    logic [15:0] close_ticks_reg;

    // input stage
    logic        in_valid_reg;
    logic [3:0]  in_mode_reg;
    logic [1:0]  in_floor_reg;

    // controller state
    tfe_state_t  state_reg;
    tfe_state_t  state_next;

    // result stage
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    logic advance;      // result register can take the item in the input stage

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    tfe_core u_core (
        .cur_state   (state_reg),
        .ev_mode     (in_mode_reg),
        .ev_floor    (in_floor_reg),
        .close_ticks (close_ticks_reg),
        .next_state  (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_ticks_reg <= DOOR_TIMEOUT_RESET;
        end else if (cfg_we) begin
            close_ticks_reg <= cfg_wdata;
        end
    end

    // input register: reloads whenever the stage is empty or moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_mode_reg  <= s_tuser;
            in_floor_reg <= s_tdata[1:0];
        end
    end

    // state and result register: the event in the input stage is applied
    // exactly once, when it moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode_state    <= ST_OPENING;
            state_reg.car_pos       <= FLOOR_1;
            state_reg.going_up      <= 1'b1;
            state_reg.going_down    <= 1'b0;
            state_reg.up_calls      <= 3'b000;
            state_reg.down_calls    <= 3'b000;
            state_reg.cabin_calls   <= 3'b000;
            state_reg.timeout_count <= 16'd0;
            state_reg.timer_armed   <= 1'b0;
            state_reg.door_cmd      <= 1'b0;
            state_reg.target        <= FLOOR_1;
            out_valid_reg           <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) state_reg <= state_next;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= {4'b0000, state_next.timer_armed, state_next.target,
                             state_next.door_cmd, state_next.cabin_calls,
                             state_next.down_calls, state_next.up_calls,
                             state_next.going_down, state_next.going_up,
                             state_next.car_pos, state_next.mode_state};
        end
    end

    // a snapshot only appears when an item stood in the input stage
    a_out_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result appeared without an input item");

    // state moves only when an item is applied
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_valid_reg) |=> $stable(state_reg))
        else $error("controller state changed without an item");

    // the door is driven closed exactly while closing or moving
    a_door_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.door_cmd == (state_reg.mode_state == ST_CLOSING ||
                               state_reg.mode_state == ST_UP ||
                               state_reg.mode_state == ST_DOWN))
        else $error("door command disagrees with controller state");

    // car position and target are always real floors
    a_floor_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.car_pos != 2'd0 && state_reg.target != 2'd0)
        else $error("car position or target left the floor range");

endmodule
